>>> rtl/great_circle_distance_core_assert.svh
// Assertion macros used by the port-level checker of the distance core.
`ifndef GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("great_circle_distance_core: check failed");

// Next-cycle implication, disabled during reset.
`define GCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("great_circle_distance_core: check failed");

`endif

>>> rtl/gcd_pkg.sv
// Shared constants, lane types and the CORDIC arctangent table of the distance core.
package gcd_pkg;

   // iteration count
   localparam int ITER_DEFAULT = 24;

   // port widths
   localparam int REQ_W  = 104;
   localparam int RSP_W  = 24;
   localparam int LAT_W  = 24;
   localparam int LON_W  = 25;
   localparam int DIST_W = 23;

   // degree to binary angle
   localparam int RED_W  = 26;
   localparam int HS_W   = 27;
   localparam int PROD_W = 53;
   localparam logic [RED_W-1:0] TURN2      = 26'd47185920;
   localparam logic [HS_W-1:0]  HALF_SCALE = 27'd95443718;

   // CORDIC datapath
   localparam int XY_W = 34;
   localparam int Z_W  = 34;
   localparam logic signed [XY_W-1:0] GAIN = 34'sd652032874;

   // Q30 products
   localparam int PW = 33;

   // square root
   localparam int RAD_W  = 62;
   localparam int REM_W  = 34;
   localparam int ROOT_W = 31;
   localparam int SQ_STEPS = 31;
   localparam logic [ROOT_W-1:0] ONE_Q30 = 31'h40000000;

   // distance scale is 2^32 + DIST_LO
   localparam logic [29:0] DIST_LO = 30'd951867617;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   flip;
   } rot_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } vec_type;

   // atan(2^-i) in binary angle units, 2^32 per turn
   function automatic logic [31:0] atan_turn(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/gcd_rot_cell.sv
// One rotation-mode CORDIC iteration with its output register.
module gcd_rot_cell #(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             en,
   input  gcd_pkg::rot_type cell_in,
   output gcd_pkg::rot_type cell_out
);

   gcd_pkg::rot_type cell_ff, cell_in_n;
   logic signed [gcd_pkg::XY_W-1:0] xi, yi, dx, dy;
   logic signed [gcd_pkg::Z_W-1:0]  zi, ang;

   // rotate toward zero residual angle
   always_comb begin
      xi  = cell_in.x;
      yi  = cell_in.y;
      zi  = cell_in.z;
      dx  = yi >>> IDX;
      dy  = xi >>> IDX;
      ang = signed'({{(gcd_pkg::Z_W-32){1'b0}}, gcd_pkg::atan_turn(5'(IDX))});
      cell_in_n.flip = cell_in.flip;
      if (!zi[gcd_pkg::Z_W-1]) begin
         cell_in_n.x = xi - dx;
         cell_in_n.y = yi + dy;
         cell_in_n.z = zi - ang;
      end else begin
         cell_in_n.x = xi + dx;
         cell_in_n.y = yi - dy;
         cell_in_n.z = zi + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_n;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/gcd_sqrt_cell.sv
// One digit step of a restoring integer square root with its output register.
module gcd_sqrt_cell (
   input  logic              clock,
   input  logic              en,
   input  gcd_pkg::sqrt_type cell_in,
   output gcd_pkg::sqrt_type cell_out
);

   gcd_pkg::sqrt_type cell_ff, cell_in_n;
   logic [gcd_pkg::REM_W-1:0] rem_sh, trial;

   // bring down two radicand bits, try the next root bit
   always_comb begin
      rem_sh = {cell_in.rem[gcd_pkg::REM_W-3:0],
                cell_in.rad[gcd_pkg::RAD_W-1:gcd_pkg::RAD_W-2]};
      trial  = {{(gcd_pkg::REM_W-gcd_pkg::ROOT_W-2){1'b0}}, cell_in.root, 2'b01};
      cell_in_n.rad = {cell_in.rad[gcd_pkg::RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         cell_in_n.rem  = rem_sh - trial;
         cell_in_n.root = {cell_in.root[gcd_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         cell_in_n.rem  = rem_sh;
         cell_in_n.root = {cell_in.root[gcd_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_n;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/gcd_vec_cell.sv
// One vectoring-mode CORDIC iteration with its output register.
module gcd_vec_cell #(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             en,
   input  gcd_pkg::vec_type cell_in,
   output gcd_pkg::vec_type cell_out
);

   gcd_pkg::vec_type cell_ff, cell_in_n;
   logic signed [gcd_pkg::XY_W-1:0] xi, yi, dx, dy;
   logic signed [gcd_pkg::Z_W-1:0]  zi, ang;

   // rotate the vector toward the x axis, accumulate the angle
   always_comb begin
      xi  = cell_in.x;
      yi  = cell_in.y;
      zi  = cell_in.z;
      dx  = yi >>> IDX;
      dy  = xi >>> IDX;
      ang = signed'({{(gcd_pkg::Z_W-32){1'b0}}, gcd_pkg::atan_turn(5'(IDX))});
      if (!yi[gcd_pkg::XY_W-1]) begin
         cell_in_n.x = xi + dx;
         cell_in_n.y = yi - dy;
         cell_in_n.z = zi + ang;
      end else begin
         cell_in_n.x = xi - dx;
         cell_in_n.y = yi + dy;
         cell_in_n.z = zi - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in_n;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/great_circle_distance_core.sv
// Throughput: one request per cycle; every stage is a register in a chain of CORDIC and
// square-root cells, and the whole chain advances whenever the result register is free.
// A result not taken holds the chain; input is taken again as soon as rsp_tready returns.
// Synchronous active-high reset clears the stage valid bits; data registers are not reset.
module great_circle_distance_core #(
   parameter int ANGLE_ITERATIONS = gcd_pkg::ITER_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // first_latitude[23:0], first_longitude[48:24], second_latitude[72:49],
   // second_longitude[97:73], zero [103:98]
   input  logic [gcd_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // distance_km[22:0] in units of 1/256 km (unsigned Q15.8), zero [23]
   output logic [gcd_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int N   = ANGLE_ITERATIONS;
   localparam int LAT = 2 * N + 39;

   logic en;
   logic [LAT-1:0] valid_ff;

   // stage 1 to 3: angle lanes (dlat, dlon, 2*lat1, 2*lat2)
   logic signed [26:0]          d_lane [4];
   logic [gcd_pkg::RED_W-1:0]   red_ff [4];
   logic [gcd_pkg::RED_W-1:0]   red_in [4];
   logic [gcd_pkg::PROD_W-1:0]  prod_ff [4];
   gcd_pkg::rot_type            rot_ff [4];
   gcd_pkg::rot_type            rot_in [4];
   gcd_pkg::rot_type            rot_bus [4][N+1];

   // haversine term
   logic signed [gcd_pkg::XY_W-1:0] su, sv, c1, c2;
   logic signed [2*gcd_pkg::XY_W-1:0] pu, pv, pc;
   logic signed [gcd_pkg::PW-1:0] u2_ff, v2_ff, c12_ff;
   logic signed [gcd_pkg::PW-1:0] u2d_ff, t_ff, t_in;
   logic signed [2*gcd_pkg::PW-1:0] pt;
   logic signed [gcd_pkg::PW:0] a_sum;
   logic [gcd_pkg::ROOT_W-1:0] a_cl;

   // square roots and final angle
   gcd_pkg::sqrt_type sq_ff [2];
   gcd_pkg::sqrt_type sq_in [2];
   gcd_pkg::sqrt_type sq_bus [2][gcd_pkg::SQ_STEPS+1];
   gcd_pkg::vec_type  vec_bus [N+1];
   logic signed [gcd_pkg::Z_W-1:0] zf;
   logic [gcd_pkg::ROOT_W-1:0] zc_ff, zc_in;
   logic [60:0] p_ff;
   logic [63:0] dist_sum;
   logic [gcd_pkg::RSP_W-1:0] rsp_tdata_ff;

   // global advance: chain moves when the result register is free
   assign en         = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   // differences and reduction to [0, 720) degrees
   always_comb begin
      d_lane[0] = 27'(signed'(req_tdata[72:49])) - 27'(signed'(req_tdata[23:0]));
      d_lane[1] = 27'(signed'(req_tdata[97:73])) - 27'(signed'(req_tdata[48:24]));
      d_lane[2] = 27'(signed'(req_tdata[23:0])) <<< 1;
      d_lane[3] = 27'(signed'(req_tdata[72:49])) <<< 1;
      for (int k = 0; k < 4; k++) begin
         if (d_lane[k][26]) begin
            red_in[k] = 26'(d_lane[k] + signed'({1'b0, gcd_pkg::TURN2}));
         end else begin
            red_in[k] = d_lane[k][25:0];
         end
      end
   end

   // half angle: round, flip to the right half plane, CORDIC start value
   always_comb begin
      logic [gcd_pkg::PROD_W:0] rs;
      logic [31:0] ang;
      logic flip;
      for (int k = 0; k < 4; k++) begin
         rs   = {1'b0, prod_ff[k]} + (54'd1 << 19);
         ang  = rs[51:20];
         flip = ang[31] ^ ang[30];
         ang  = ang ^ {flip, 31'd0};
         rot_in[k].x    = gcd_pkg::GAIN;
         rot_in[k].y    = '0;
         rot_in[k].z    = gcd_pkg::Z_W'(signed'(ang));
         rot_in[k].flip = flip;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            red_ff[k]  <= red_in[k];
            prod_ff[k] <= gcd_pkg::PROD_W'(red_ff[k]) * gcd_pkg::PROD_W'(gcd_pkg::HALF_SCALE);
            rot_ff[k]  <= rot_in[k];
         end
      end
   end

   // rotation chains, one per angle lane
   for (genvar k = 0; k < 4; k++) begin : g_rot_lane
      assign rot_bus[k][0] = rot_ff[k];
      for (genvar i = 0; i < N; i++) begin : g_rot
         gcd_rot_cell #(.IDX(i)) u_cell (
            .clock   (clock),
            .en      (en),
            .cell_in (rot_bus[k][i]),
            .cell_out(rot_bus[k][i+1])
         );
      end
   end

   // sines and cosines with the half-plane flip undone, Q30 products
   always_comb begin
      su = rot_bus[0][N].flip ? -rot_bus[0][N].y : rot_bus[0][N].y;
      sv = rot_bus[1][N].flip ? -rot_bus[1][N].y : rot_bus[1][N].y;
      c1 = rot_bus[2][N].flip ? -rot_bus[2][N].x : rot_bus[2][N].x;
      c2 = rot_bus[3][N].flip ? -rot_bus[3][N].x : rot_bus[3][N].x;
      pu = 68'(su) * 68'(su);
      pv = 68'(sv) * 68'(sv);
      pc = 68'(c1) * 68'(c2);
   end

   // cos*cos*sin^2 term, then sum and clamp to [0, 1]
   always_comb begin
      pt    = 66'(c12_ff) * 66'(v2_ff);
      t_in  = gcd_pkg::PW'(pt >>> 30);
      a_sum = (gcd_pkg::PW+1)'(u2d_ff) + (gcd_pkg::PW+1)'(t_ff);
      if (a_sum[gcd_pkg::PW]) begin
         a_cl = '0;
      end else if (a_sum > signed'({3'b000, gcd_pkg::ONE_Q30})) begin
         a_cl = gcd_pkg::ONE_Q30;
      end else begin
         a_cl = a_sum[gcd_pkg::ROOT_W-1:0];
      end
      sq_in[0].rad  = {1'b0, a_cl, 30'd0};
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      sq_in[1].rad  = {1'b0, gcd_pkg::ONE_Q30 - a_cl, 30'd0};
      sq_in[1].rem  = '0;
      sq_in[1].root = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u2_ff  <= gcd_pkg::PW'(pu >>> 30);
         v2_ff  <= gcd_pkg::PW'(pv >>> 30);
         c12_ff <= gcd_pkg::PW'(pc >>> 30);
         u2d_ff <= u2_ff;
         t_ff   <= t_in;
         sq_ff  <= sq_in;
      end
   end

   // square roots of a and 1-a
   for (genvar k = 0; k < 2; k++) begin : g_sq_lane
      assign sq_bus[k][0] = sq_ff[k];
      for (genvar i = 0; i < gcd_pkg::SQ_STEPS; i++) begin : g_sq
         gcd_sqrt_cell u_cell (
            .clock   (clock),
            .en      (en),
            .cell_in (sq_bus[k][i]),
            .cell_out(sq_bus[k][i+1])
         );
      end
   end

   // asin(sqrt(a)) as atan2(sqrt(a), sqrt(1-a))
   assign vec_bus[0].x = gcd_pkg::XY_W'(sq_bus[1][gcd_pkg::SQ_STEPS].root);
   assign vec_bus[0].y = gcd_pkg::XY_W'(sq_bus[0][gcd_pkg::SQ_STEPS].root);
   assign vec_bus[0].z = '0;

   for (genvar i = 0; i < N; i++) begin : g_vec
      gcd_vec_cell #(.IDX(i)) u_cell (
         .clock   (clock),
         .en      (en),
         .cell_in (vec_bus[i]),
         .cell_out(vec_bus[i+1])
      );
   end

   // clamp angle to [0, 90] degrees, scale to kilometres
   always_comb begin
      zf = vec_bus[N].z;
      if (zf[gcd_pkg::Z_W-1]) begin
         zc_in = '0;
      end else if (zf > signed'({3'b000, gcd_pkg::ONE_Q30})) begin
         zc_in = gcd_pkg::ONE_Q30;
      end else begin
         zc_in = zf[gcd_pkg::ROOT_W-1:0];
      end
      dist_sum = {1'b0, zc_ff, 32'd0} + {3'b000, p_ff} + (64'd1 << 39);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zc_ff        <= zc_in;
         p_ff         <= 61'(zc_in) * 61'(gcd_pkg::DIST_LO);
         rsp_tdata_ff <= {1'b0, dist_sum[62:40]};
      end
   end

endmodule

>>> rtl/gcd_checker.sv
// Port-level checker of the distance core and its bind to the top level.
`include "great_circle_distance_core_assert.svh"

module gcd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [gcd_pkg::RSP_W-1:0] rsp_tdata
);

   // a stalled result holds its data
   `GCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // distance never exceeds half the circumference, pad bit stays zero
   `GCD_ASSERT_NOW(a_rsp_range, clock, reset, rsp_tvalid, rsp_tdata[23] == 1'b0 && rsp_tdata[22:0] <= 23'd5123862)
   // an empty result register never blocks requests
   `GCD_ASSERT_NOW(a_req_open, clock, reset, !rsp_tvalid, req_tready)
   // a waiting result holds the whole chain
   `GCD_ASSERT_NOW(a_req_stall, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)

endmodule

bind great_circle_distance_core gcd_checker u_gcd_checker (.*);

>>> verif/great_circle_distance_core_checker.sv
// Request/response monitor, distance predictor and scoreboard for the distance core.
`timescale 1ns / 100ps
module great_circle_distance_core_checker #(
   parameter int ANGLE_ITERATIONS = gcd_pkg::ITER_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [gcd_pkg::REQ_W-1:0] req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [gcd_pkg::RSP_W-1:0] rsp_tdata,
   output int                        fail_count,
   output int                        pending
);
   import gcd_pkg::*;

   localparam longint TURN2_DEG = 64'd47185920;
   localparam longint HALF_MUL  = ((64'd1 << 51) + 64'd11796480) / 64'd23592960;
   localparam longint Q30_ONE   = 64'd1 << 30;
   localparam longint CG        = 64'd652032874;
   localparam longint unsigned KM_SCALE = 64'd5246834913;

   logic [DIST_W-1:0] distance_queue[$];

   function automatic longint atan_step(int i);
      longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                        81, 41, 20, 10, 5, 3, 1, 1, 0};
      return t[i];
   endfunction

   // half of d (degrees * 65536) as a binary angle
   function automatic logic [31:0] half_turn(longint d);
      longint r;
      longint unsigned p;
      r = d + TURN2_DEG;
      if (r >= TURN2_DEG) r -= TURN2_DEG;
      if (r < 0) r += TURN2_DEG;
      p = (longint'(r) * HALF_MUL + (64'd1 << 19)) >> 20;
      return p[31:0];
   endfunction

   // rotation CORDIC with half-turn fold
   function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
      logic   flip;
      longint x, y, z, dx, dy;
      flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
      if (flip) ang = ang + 32'h8000_0000;
      z = longint'($signed(ang));
      x = CG;
      y = 0;
      for (int i = 0; i < ANGLE_ITERATIONS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [DIST_W-1:0] predict_distance(logic [REQ_W-1:0] d);
      longint lat1, lon1, lat2, lon2;
      longint cu, su, cv, sv, c1, s1, c2, s2, u2, v2, c12, a, x, y, z, dx, dy;
      longint unsigned km;
      lat1 = longint'($signed(d[23:0]));
      lon1 = longint'($signed(d[48:24]));
      lat2 = longint'($signed(d[72:49]));
      lon2 = longint'($signed(d[97:73]));
      rotate(half_turn(lat2 - lat1), cu, su);
      rotate(half_turn(lon2 - lon1), cv, sv);
      rotate(half_turn(2 * lat1), c1, s1);
      rotate(half_turn(2 * lat2), c2, s2);
      u2  = (su * su) >>> 30;
      v2  = (sv * sv) >>> 30;
      c12 = (c1 * c2) >>> 30;
      a   = u2 + ((c12 * v2) >>> 30);
      if (a < 0) a = 0;
      if (a > Q30_ONE) a = Q30_ONE;
      // vectoring CORDIC on (sqrt(1-a), sqrt(a))
      y = longint'(int_sqrt(longint'(a) << 30));
      x = longint'(int_sqrt(longint'(Q30_ONE - a) << 30));
      z = 0;
      for (int i = 0; i < ANGLE_ITERATIONS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_step(i);
         end else begin
            x -= dx; y += dy; z -= atan_step(i);
         end
      end
      if (z < 0) z = 0;
      if (z > Q30_ONE) z = Q30_ONE;
      km = (longint'(z) * KM_SCALE + (64'd1 << 39)) >> 40;
      return km[DIST_W-1:0];
   endfunction

   assign pending = distance_queue.size();

   // predict on accepted requests, compare on accepted results
   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            distance_queue.push_back(predict_distance(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (distance_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected result %h", rsp_tdata);
            end else begin
               want = {1'b0, distance_queue.pop_front()};
               if (rsp_tdata !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("distance mismatch: expected %h got %h", want, rsp_tdata);
               end
            end
         end
      end
   end
endmodule

>>> verif/great_circle_distance_core_tb.sv
// Stimulus and verdict for the great-circle distance core.
`timescale 1ns / 100ps
module great_circle_distance_core_tb;
   import gcd_pkg::*;

   localparam int LAT_MAX = 5898240;
   localparam int LON_MAX = 11796480;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;

   great_circle_distance_core dut (.*);
   great_circle_distance_core_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver backpressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [REQ_W-1:0] pack_points(int la1, int lo1, int la2, int lo2);
      return {6'b0, lo2[24:0], la2[23:0], lo1[24:0], la1[23:0]};
   endfunction

   function automatic int rand_lat();
      return int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
   endfunction

   function automatic int rand_lon();
      return int'($urandom_range(2 * LON_MAX)) - LON_MAX;
   endfunction

   // one request; valid stays high across back-to-back requests
   task automatic send_request(logic [REQ_W-1:0] d);
      logic taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic send_random(int n);
      int k;
      logic [31:0] r;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(9);
         r = $urandom();
         if (k < 7)
            send_request(pack_points(rand_lat(), rand_lon(), rand_lat(), rand_lon()));
         else if (k == 7)
            // nearby points
            send_request(pack_points(LAT_MAX / 2, 100, LAT_MAX / 2 + int'($urandom_range(64)),
                                     100 + int'($urandom_range(64))));
         else
            // full field width, out of range included
            send_request({6'b0, r[1:0], $urandom(), $urandom(), $urandom()});
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, poles, antipodes, identical points, wrap
      send_request(pack_points(0, 0, 0, 0));
      send_request(pack_points(LAT_MAX, 0, -LAT_MAX, 0));
      send_request(pack_points(0, 0, 0, LON_MAX));
      send_request(pack_points(0, -LON_MAX, 0, LON_MAX));
      send_request(pack_points(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX));
      send_request(pack_points(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX));
      send_request(pack_points(LAT_MAX, 0, LAT_MAX, LON_MAX));
      send_request(pack_points(LAT_MAX / 2, 0, -LAT_MAX / 2, LON_MAX));
      send_request(pack_points(0, 1, 0, 0));
      send_request(pack_points(1, 0, 0, 0));
      send_request(pack_points(0, 0, 0, LON_MAX / 2));
      send_request(pack_points(0, LON_MAX - 1, 0, -LON_MAX + 1));
      send_request(pack_points(2**23 - 1, 2**24 - 1, -(2**23), -(2**24)));
      send_request(pack_points(-(2**23), -(2**24), 2**23 - 1, 2**24 - 1));
      send_request(pack_points(7000000, 0, 7000000, 5000000));
      send_request(pack_points(-7000000, 100, 7000000, -100));
      send_request(pack_points(LAT_MAX, 123456, LAT_MAX, -654321));
      send_request({6'b0, {98{1'b1}}});
      send_request(pack_points(3276800, 327680, 3276800, 327680));

      send_random(175);
      send_idle_pct = 87;
      send_random(175);
      send_idle_pct = 0;
      recv_stall_pct = 87;
      send_random(175);
      send_idle_pct = 28;
      recv_stall_pct = 28;
      send_random(175);
      req_tvalid <= 1'b0;
      recv_stall_pct = 0;

      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

>>> sim.f
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_rot_cell.sv
rtl/gcd_sqrt_cell.sv
rtl/gcd_vec_cell.sv
rtl/great_circle_distance_core.sv
rtl/gcd_checker.sv
verif/great_circle_distance_core_checker.sv
verif/great_circle_distance_core_tb.sv
